@@ hw/rtl/calendar_clock_set_adjust_top_defines.svh @@
// Assertion macros for the calendar clock block
`ifndef CALENDAR_CLOCK_SET_ADJUST_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_SET_ADJUST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CCSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar clock assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define CCSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar clock assertion failed");

`endif

@@ hw/rtl/ccsa_pkg.sv @@
// Shared types, constants and the month length table of the calendar clock
`timescale 1ns / 1ps

package ccsa_pkg;

  typedef enum logic [1:0] {
    FUNC_CARRY = 2'd0,
    FUNC_INC   = 2'd1,
    FUNC_DEC   = 2'd2
  } ccsa_func_e;

  typedef enum logic [2:0] {
    FIELD_YEAR   = 3'd0,
    FIELD_MONTH  = 3'd1,
    FIELD_DAY    = 3'd2,
    FIELD_HOUR   = 3'd3,
    FIELD_MINUTE = 3'd4,
    FIELD_SECOND = 3'd5
  } ccsa_field_e;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINSEC_MAX = 6'd59;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ccsa_date_t;

  typedef struct packed {
    logic       fire;
    logic [1:0] func;
    logic [2:0] sel;
  } ccsa_cmd_t;

  // Days in a month; codes outside 1..12 count as 31-day months
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/ccsa_core.sv @@
// Date and time registers with the carry, increment and decrement logic
`timescale 1ns / 1ps

module ccsa_core import ccsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ccsa_cmd_t  cmd_i,
  output ccsa_date_t date_d_o
);

  localparam logic [6:0] YMOD_LAST = 7'd99;

  ccsa_date_t date_q, date_d;
  // year mod 100 and (year / 100) mod 4, kept alongside the year for the leap test
  logic [6:0] ymod_q, ymod_d;
  logic [1:0] cent_q, cent_d;

  logic       leap;
  logic [4:0] mlen;
  logic [3:0] month_next;
  logic       day_over;

  ccsa_date_t  up_date;
  logic [6:0]  up_ymod;
  logic [1:0]  up_cent;

  assign leap     = (date_q.year[1:0] == 2'd0) && ((ymod_q != 7'd0) || (cent_q == 2'd0));
  assign mlen     = month_len(date_q.month, leap);
  assign day_over = date_q.day > mlen;
  assign month_next = day_over ? date_q.month + 4'd1 : date_q.month;

  // Year advance, wrapping the last year to zero
  always_comb begin
    up_date = date_q;
    up_ymod = ymod_q;
    up_cent = cent_q;
    if (date_q.year >= YEAR_MAX) begin
      up_date.year = 14'd0;
      up_ymod      = 7'd0;
      up_cent      = 2'd0;
    end else begin
      up_date.year = date_q.year + 14'd1;
      if (ymod_q >= YMOD_LAST) begin
        up_ymod = 7'd0;
        up_cent = cent_q + 2'd1;
      end else begin
        up_ymod = ymod_q + 7'd1;
      end
    end
  end

  always_comb begin
    date_d = date_q;
    ymod_d = ymod_q;
    cent_d = cent_q;
    if (cmd_i.fire) begin
      case (cmd_i.func)
        FUNC_CARRY: begin
          if (day_over) date_d.day = 5'd1;
          date_d.month = month_next;
          if (month_next > MONTH_MAX) begin
            date_d.month = 4'd1;
            date_d.year  = up_date.year;
            ymod_d       = up_ymod;
            cent_d       = up_cent;
          end
        end
        FUNC_INC: begin
          case (cmd_i.sel)
            FIELD_YEAR: begin
              date_d.year = up_date.year;
              ymod_d      = up_ymod;
              cent_d      = up_cent;
            end
            FIELD_MONTH:
              date_d.month = (date_q.month >= MONTH_MAX) ? 4'd1 : date_q.month + 4'd1;
            FIELD_DAY:
              date_d.day = (date_q.day >= mlen) ? 5'd1 : date_q.day + 5'd1;
            FIELD_HOUR:
              date_d.hour = (date_q.hour >= HOUR_MAX) ? 5'd0 : date_q.hour + 5'd1;
            FIELD_MINUTE:
              date_d.minute = (date_q.minute >= MINSEC_MAX) ? 6'd0 : date_q.minute + 6'd1;
            FIELD_SECOND:
              date_d.second = (date_q.second >= MINSEC_MAX) ? 6'd0 : date_q.second + 6'd1;
            default: ;
          endcase
        end
        FUNC_DEC: begin
          case (cmd_i.sel)
            FIELD_YEAR: begin
              // hold at year zero
              if (date_q.year != 14'd0) begin
                date_d.year = date_q.year - 14'd1;
                if (ymod_q == 7'd0) begin
                  ymod_d = YMOD_LAST;
                  cent_d = cent_q - 2'd1;
                end else begin
                  ymod_d = ymod_q - 7'd1;
                end
              end
            end
            FIELD_MONTH:
              date_d.month = (date_q.month <= 4'd1) ? MONTH_MAX : date_q.month - 4'd1;
            FIELD_DAY:
              date_d.day = (date_q.day <= 5'd1) ? mlen : date_q.day - 5'd1;
            FIELD_HOUR:
              date_d.hour = (date_q.hour == 5'd0) ? HOUR_MAX : date_q.hour - 5'd1;
            FIELD_MINUTE:
              date_d.minute = (date_q.minute == 6'd0) ? MINSEC_MAX : date_q.minute - 6'd1;
            FIELD_SECOND:
              date_d.second = (date_q.second == 6'd0) ? MINSEC_MAX : date_q.second - 6'd1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q <= '{year: 14'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
                  second: 6'd0};
      ymod_q <= 7'd0;
      cent_q <= 2'd0;
    end else begin
      date_q <= date_d;
      ymod_q <= ymod_d;
      cent_q <= cent_d;
    end
  end

  assign date_d_o = date_d;

endmodule

@@ hw/rtl/calendar_clock_set_adjust_top.sv @@
// Top level of the calendar clock: input register, date core, result register
`timescale 1ns / 1ps
`include "calendar_clock_set_adjust_top_defines.svh"

// Calendar clock with set and adjust commands.
// Input channel: func_i and field_sel_i, taken when in_valid_i is high and
// in_stall_o is low. func 0 runs the day-end carry, 1 increments and 2
// decrements the field picked by field_sel_i; other codes change nothing.
// Output channel: all six date and time fields as one word, taken when
// out_valid_o is high and out_stall_i is low. Every input word gives one
// output word, in order.
// A command word passes the input register, then the result register, which
// raises out_valid_o; an output stall can hold it between. Throughput: one
// word per cycle while out_stall_i is low; date registers update in the same
// cycle that the result register loads, so a command sees the last one's date.
// When the receiver stalls, the result register holds its word, the input
// register fills, and in_stall_o rises until the result word is taken.
// Reset sets the date to year 0, month 1, day 1, 00:00:00 and empties
// both registers.
module calendar_clock_set_adjust_top import ccsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  field_sel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o
);

  logic       in_v_q, in_v_d;
  logic [1:0] func_q;
  logic [2:0] sel_q;
  logic       out_v_q, out_v_d;
  ccsa_date_t res_q;
  ccsa_date_t date_nxt;
  ccsa_cmd_t  cmd;
  logic       out_free;
  logic       in_take;

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = in_v_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cmd.fire = in_v_q && out_free;
  assign cmd.func = func_q;
  assign cmd.sel  = sel_q;

  ccsa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .date_d_o (date_nxt)
  );

  always_comb begin
    in_v_d = in_v_q;
    if (in_take) in_v_d = 1'b1;
    else if (cmd.fire) in_v_d = 1'b0;
    out_v_d = out_v_q;
    if (cmd.fire) out_v_d = 1'b1;
    else if (out_v_q && !out_stall_i) out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers: load on the handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= func_i;
      sel_q  <= field_sel_i;
    end
    if (cmd.fire) res_q <= date_nxt;
  end

  assign out_valid_o  = out_v_q;
  assign year_out_o   = res_q.year;
  assign month_out_o  = res_q.month;
  assign day_out_o    = res_q.day;
  assign hour_out_o   = res_q.hour;
  assign minute_out_o = res_q.minute;
  assign second_out_o = res_q.second;

  `CCSA_ASSERT_IMPL(a_stall_from_output, in_stall_o, out_v_q && out_stall_i && in_v_q)
  `CCSA_ASSERT_NEXT(a_fire_gives_word, cmd.fire, out_valid_o && (res_q == $past(date_nxt)))
  `CCSA_ASSERT_IMPL(a_month_range, out_valid_o,
                    (month_out_o >= 4'd1) && (month_out_o <= MONTH_MAX))
  `CCSA_ASSERT_IMPL(a_time_range, out_valid_o,
                    (year_out_o <= YEAR_MAX) && (hour_out_o <= HOUR_MAX) && (day_out_o != 5'd0))

endmodule

@@ bench/calendar_clock_set_adjust_top_tb.sv @@
// Self-checking testbench for the calendar clock set and adjust block
`timescale 1ns / 1ps

module calendar_clock_set_adjust_top_tb;
  import ccsa_pkg::*;

  localparam logic [1:0]  FUNC_NONE      = 2'd3;
  localparam logic [2:0]  FIELD_SPARE_LO = 3'd6;
  localparam logic [2:0]  FIELD_SPARE_HI = 3'd7;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  func_i      = FUNC_CARRY;
  logic [2:0]  field_sel_i = FIELD_YEAR;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [13:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;

  ccsa_date_t  date_now;
  ccsa_date_t  pending_dates[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;
  int unsigned date_commands = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  calendar_clock_set_adjust_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .field_sel_i  (field_sel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .year_out_o   (year_out_o),
    .month_out_o  (month_out_o),
    .day_out_o    (day_out_o),
    .hour_out_o   (hour_out_o),
    .minute_out_o (minute_out_o),
    .second_out_o (second_out_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic [13:0] year);
    logic leap;
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    case (month)
      4'd2:                    return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic ccsa_date_t next_date(input ccsa_date_t d, input logic [1:0] func,
                                           input logic [2:0] sel);
    logic [4:0] len;
    len = month_days(d.month, d.year);
    case (func)
      FUNC_CARRY: begin
        if (d.day > len) begin
          d.day   = 5'd1;
          d.month = d.month + 4'd1;
        end
        if (d.month > MONTH_MAX) begin
          d.month = 4'd1;
          d.year  = (d.year >= YEAR_MAX) ? 14'd0 : d.year + 14'd1;
        end
      end
      FUNC_INC: begin
        case (sel)
          FIELD_YEAR:   d.year   = (d.year >= YEAR_MAX) ? 14'd0 : d.year + 14'd1;
          FIELD_MONTH:  d.month  = (d.month >= MONTH_MAX) ? 4'd1 : d.month + 4'd1;
          FIELD_DAY:    d.day    = (d.day >= len) ? 5'd1 : d.day + 5'd1;
          FIELD_HOUR:   d.hour   = (d.hour >= HOUR_MAX) ? 5'd0 : d.hour + 5'd1;
          FIELD_MINUTE: d.minute = (d.minute >= MINSEC_MAX) ? 6'd0 : d.minute + 6'd1;
          FIELD_SECOND: d.second = (d.second >= MINSEC_MAX) ? 6'd0 : d.second + 6'd1;
          default: ;
        endcase
      end
      FUNC_DEC: begin
        case (sel)
          FIELD_YEAR:   d.year   = (d.year == 14'd0) ? 14'd0 : d.year - 14'd1;
          FIELD_MONTH:  d.month  = (d.month <= 4'd1) ? MONTH_MAX : d.month - 4'd1;
          FIELD_DAY:    d.day    = (d.day <= 5'd1) ? len : d.day - 5'd1;
          FIELD_HOUR:   d.hour   = (d.hour == 5'd0) ? HOUR_MAX : d.hour - 5'd1;
          FIELD_MINUTE: d.minute = (d.minute == 6'd0) ? MINSEC_MAX : d.minute - 6'd1;
          FIELD_SECOND: d.second = (d.second == 6'd0) ? MINSEC_MAX : d.second - 6'd1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return d;
  endfunction

  // Hand one command word to the block; predict the date once it is taken
  task automatic drive_word(input logic [1:0] func, input logic [2:0] sel);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= func;
    field_sel_i <= sel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    date_now = next_date(date_now, func, sel);
    pending_dates.push_back(date_now);
    words_sent++;
    if (func == FUNC_CARRY || (func != FUNC_NONE && sel <= FIELD_SECOND)) date_commands++;
  endtask

  // Hold off the sender until every predicted date has come back
  task automatic wait_all_back();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // Increment one field until the predicted date holds the target value
  task automatic steer(input ccsa_field_e fld, input int unsigned target);
    int unsigned guard;
    int unsigned cur;
    guard = 0;
    forever begin
      case (fld)
        FIELD_YEAR:   cur = 32'(date_now.year);
        FIELD_MONTH:  cur = 32'(date_now.month);
        FIELD_DAY:    cur = 32'(date_now.day);
        FIELD_HOUR:   cur = 32'(date_now.hour);
        FIELD_MINUTE: cur = 32'(date_now.minute);
        default:      cur = 32'(date_now.second);
      endcase
      if (cur == target || guard > 10000) break;
      drive_word(FUNC_INC, fld);
      guard++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input logic [13:0] got);
    if (got !== want[13:0]) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Mismatch on word %0d, %s: expected %0d, got %0d", words_checked, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    ccsa_date_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Unexpected result word: %0d-%0d-%0d %0d:%0d:%0d", year_out_o, month_out_o,
                   day_out_o, hour_out_o, minute_out_o, second_out_o);
      end else begin
        want = pending_dates.pop_front();
        check_field("year", 32'(want.year), year_out_o);
        check_field("month", 32'(want.month), 14'(month_out_o));
        check_field("day", 32'(want.day), 14'(day_out_o));
        check_field("hour", 32'(want.hour), 14'(hour_out_o));
        check_field("minute", 32'(want.minute), 14'(minute_out_o));
        check_field("second", 32'(want.second), 14'(second_out_o));
        words_checked++;
      end
    end
  end

  // Count cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_dates.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // From reset, wrap every field but the year and hold the year at zero; also unused function codes and selectors
  task automatic test_reset_and_wraps();
    drive_word(FUNC_CARRY, FIELD_YEAR);
    drive_word(FUNC_NONE, FIELD_YEAR);
    drive_word(FUNC_NONE, FIELD_SPARE_HI);
    drive_word(FUNC_INC, FIELD_SPARE_LO);
    drive_word(FUNC_DEC, FIELD_SPARE_HI);
    drive_word(FUNC_INC, FIELD_SPARE_HI);
    drive_word(FUNC_DEC, FIELD_YEAR);
    drive_word(FUNC_DEC, FIELD_MONTH);
    drive_word(FUNC_DEC, FIELD_DAY);
    drive_word(FUNC_DEC, FIELD_HOUR);
    drive_word(FUNC_DEC, FIELD_MINUTE);
    drive_word(FUNC_DEC, FIELD_SECOND);
    drive_word(FUNC_INC, FIELD_HOUR);
    drive_word(FUNC_INC, FIELD_MINUTE);
    drive_word(FUNC_INC, FIELD_SECOND);
    drive_word(FUNC_INC, FIELD_MONTH);
    drive_word(FUNC_INC, FIELD_DAY);
    drive_word(FUNC_INC, FIELD_YEAR);
    drive_word(FUNC_DEC, FIELD_YEAR);
    drive_word(FUNC_CARRY, FIELD_SPARE_HI);
    wait_all_back();
  endtask

  task automatic test_month_ends();
    // day past the end of a short month, then carry
    steer(FIELD_MONTH, 1);
    steer(FIELD_DAY, 31);
    drive_word(FUNC_INC, FIELD_MONTH);
    drive_word(FUNC_INC, FIELD_DAY);
    steer(FIELD_MONTH, 1);
    steer(FIELD_DAY, 31);
    drive_word(FUNC_INC, FIELD_MONTH);
    drive_word(FUNC_CARRY, FIELD_YEAR);
    steer(FIELD_DAY, 31);
    drive_word(FUNC_INC, FIELD_MONTH);
    drive_word(FUNC_DEC, FIELD_DAY);
    drive_word(FUNC_CARRY, FIELD_YEAR);
    steer(FIELD_MONTH, 3);
    steer(FIELD_DAY, 31);
    drive_word(FUNC_INC, FIELD_MONTH);
    drive_word(FUNC_CARRY, FIELD_YEAR);
    // last day of the year must not carry
    steer(FIELD_MONTH, 12);
    steer(FIELD_DAY, 31);
    drive_word(FUNC_CARRY, FIELD_YEAR);
    wait_all_back();
  endtask

  // Probe February in a 400-year leap case, two 4-year leap cases and a 100-year
  // non-leap case, then step the year down and up across a century boundary
  task automatic test_year_sweep();
    int unsigned probe_years[4];
    probe_years = '{0, 4, 100, 104};
    foreach (probe_years[i]) begin
      steer(FIELD_YEAR, probe_years[i]);
      steer(FIELD_MONTH, 2);
      steer(FIELD_DAY, 1);
      drive_word(FUNC_DEC, FIELD_DAY);
      drive_word(FUNC_INC, FIELD_DAY);
      steer(FIELD_MONTH, 1);
      steer(FIELD_DAY, 29);
      drive_word(FUNC_INC, FIELD_MONTH);
      drive_word(FUNC_CARRY, FIELD_YEAR);
    end
    repeat (5) drive_word(FUNC_DEC, FIELD_YEAR);
    drive_word(FUNC_INC, FIELD_YEAR);
    wait_all_back();
  endtask

  task automatic test_random_mix(input int unsigned quota, input int unsigned tx_pct,
                                 input int unsigned rx_pct);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  func;
    logic [2:0]  sel;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    stop_at = date_commands + quota;
    while (date_commands < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // run the day to 28 or later in the month, move the month, then carry
        steer(FIELD_MONTH, $urandom_range(1, 12));
        steer(FIELD_DAY, $urandom_range(28, month_days(date_now.month, date_now.year)));
        drive_word(2'($urandom_range(FUNC_INC, FUNC_DEC)), FIELD_MONTH);
        drive_word(FUNC_CARRY, 3'($urandom_range(7)));
      end else begin
        if (pick < 11) begin
          func = FUNC_NONE;
          sel  = 3'($urandom_range(7));
        end else if (pick < 17) begin
          func = 2'($urandom_range(FUNC_INC, FUNC_DEC));
          sel  = 3'($urandom_range(FIELD_SPARE_LO, FIELD_SPARE_HI));
        end else if (pick < 37) begin
          func = FUNC_CARRY;
          sel  = 3'($urandom_range(7));
        end else begin
          func = 2'($urandom_range(FUNC_INC, FUNC_DEC));
          sel  = 3'($urandom_range(FIELD_SECOND));
        end
        drive_word(func, sel);
      end
    end
    wait_all_back();
  endtask

  initial begin
    date_now = '{year: 14'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 45;
    test_reset_and_wraps();
    test_month_ends();
    test_year_sweep();
    test_random_mix(300, 30, 45);
    test_random_mix(300, 45, 30);
    test_random_mix(300, 0, 0);

    repeat (8) @(posedge clk_i);
    $display("Sent %0d command words (%0d date commands), checked %0d result words",
             words_sent, date_commands, words_checked);
    $display("Covered field wraps, month ends, leap rules and century steps; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
